FILE: sv/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants and types for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;     // apply the accepted command to indices, count and ring
        logic rd_en;    // capture the front and rear entries
    } dp_cmd_t;

endpackage

FILE: sv/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accepts one item, lets the datapath update and read, then
// presents the result until it is taken.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output handshakes open together");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> cmd.rd_en)
        else $error("accepted item was not followed by a read");

endmodule

FILE: sv/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath
// Ring storage, head and tail indices, occupancy and result registers.
// ----------------------------------------------------------------------------
module cdq_datapath
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     overflow,
    output logic                     underflow,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] rear_value,
    output logic [COUNT_W-1:0]       count,
    output logic                     is_empty
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

    logic [DATA_W-1:0] ring_mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic              ovf_reg, ovf_next;
    logic              unf_reg, unf_next;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] rear_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    cmd_t              op;

    assign op = cmd_t'(command);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        ovf_next  = 1'b0;
        unf_next  = 1'b0;
        wr_en     = 1'b0;
        wr_idx    = '0;
        case (op)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (occ_reg == '0)
                begin
                    // The first word of an empty ring always lands in slot zero.
                    head_next = '0;
                    tail_next = '0;
                    occ_next  = OCC_W'(1);
                    wr_en     = 1'b1;
                end
                else if (occ_reg >= OCC_FULL)
                begin
                    ovf_next = 1'b1;
                end
                else if (op == CMD_PUSH_FRONT)
                begin
                    head_next = (head_reg == '0) ? IDX_LAST : head_reg - IDX_W'(1);
                    wr_idx    = head_next;
                    occ_next  = occ_reg + OCC_W'(1);
                    wr_en     = 1'b1;
                end
                else
                begin
                    tail_next = (tail_reg == IDX_LAST) ? '0 : tail_reg + IDX_W'(1);
                    wr_idx    = tail_next;
                    occ_next  = occ_reg + OCC_W'(1);
                    wr_en     = 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (occ_reg == '0)
                begin
                    unf_next = 1'b1;
                end
                else if (occ_reg == OCC_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                    occ_next  = '0;
                end
                else if (op == CMD_POP_FRONT)
                begin
                    head_next = (head_reg == IDX_LAST) ? '0 : head_reg + IDX_W'(1);
                    occ_next  = occ_reg - OCC_W'(1);
                end
                else
                begin
                    tail_next = (tail_reg == '0) ? IDX_LAST : tail_reg - IDX_W'(1);
                    occ_next  = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            ovf_reg  <= 1'b0;
            unf_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            ovf_reg  <= ovf_next;
            unf_reg  <= unf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            ring_mem[wr_idx] <= value;
        end
    end

    // Reads happen in the cycle after the write, so the new word is visible.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            front_reg <= ring_mem[head_reg];
            rear_reg  <= ring_mem[tail_reg];
        end
    end

    assign overflow    = ovf_reg;
    assign underflow   = unf_reg;
    assign is_empty    = (occ_reg == '0);
    assign front_value = is_empty ? '0 : front_reg;
    assign rear_value  = is_empty ? '0 : rear_reg;
    assign count       = COUNT_W'(occ_reg);

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("occupancy beyond ring depth");

    a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty ring with non-zero indices");

    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ovf_reg && unf_reg))
        else $error("overflow and underflow flagged together");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && ovf_next) |=> (occ_reg == OCC_FULL))
        else $error("overflow flagged on a ring that is not full");

endmodule

FILE: sv/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Each item is one command (push front, push back, pop front, pop back) and
// produces one result with the overflow and underflow flags, the front and
// rear words (zero when empty), the word count and an empty flag. The cycle
// in which an item is accepted updates the indices, count and ring entry at
// its closing edge. The next cycle performs the registered read of the front
// and rear entries from the ring memory. After the read the result is offered.
// The next item is accepted in the cycle after the result is taken, so output
// stalls add directly to the time per item.
// The ring memory needs no clearing after reset.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     overflow,
    output logic                     underflow,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] rear_value,
    output logic [COUNT_W-1:0]       count,
    output logic                     is_empty
);

    dp_cmd_t dp_cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd)
    );

    cdq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .command     (command),
        .value       (value),
        .overflow    (overflow),
        .underflow   (underflow),
        .front_value (front_value),
        .rear_value  (rear_value),
        .count       (count),
        .is_empty    (is_empty)
    );

endmodule

FILE: test/circular_deque_test.sv
// ----------------------------------------------------------------------------
// circular_deque_test
// Self-checking testbench for the circular double-ended queue.
// ----------------------------------------------------------------------------
// A clocked driver takes command items from a pending queue and offers them
// on the input channel. Each accepted item is run through a local model of
// the ring, and the result it should give is queued. A clocked monitor takes
// the results and compares every field with the oldest queued result. A short
// directed sequence covers the corner cases. Random bursts that lean towards
// pushing or popping then drive the ring to full and to empty many times,
// under three patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module circular_deque_test
    import cdq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 750;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] word;
    } command_item_t;

    typedef struct {
        logic                     overflow;
        logic                     underflow;
        logic signed [DATA_W-1:0] front_word;
        logic signed [DATA_W-1:0] rear_word;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } deque_result_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [1:0]               command   = CMD_PUSH_FRONT;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     overflow;
    logic                     underflow;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;

    command_item_t pending_items[$];
    deque_result_t expected_results[$];

    // Local copy of the ring.
    logic signed [DATA_W-1:0] ring_words [DEPTH];
    int unsigned              front_slot = 0;
    int unsigned              rear_slot  = 0;
    int unsigned              word_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int overflows_seen = 0;
    int underflows_seen = 0;
    int full_seen      = 0;
    int cmd_seen [4]   = '{0, 0, 0, 0};
    int cycles         = 0;

    circular_deque dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .overflow    (overflow),
        .underflow   (underflow),
        .front_value (front_value),
        .rear_value  (rear_value),
        .count       (count),
        .is_empty    (is_empty)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, expected_results.size());
            $display("[circular_deque] ERROR");
            $finish;
        end
    end

    // Applies one command to the local ring and returns the result it gives.
    function automatic deque_result_t apply_command(cmd_t cmd,
                                                    logic signed [DATA_W-1:0] word);
        deque_result_t r;
        r = '{default: '0};
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
        begin
            if (word_count == 0)
            begin
                front_slot    = 0;
                rear_slot     = 0;
                ring_words[0] = word;
                word_count    = 1;
            end
            else if (word_count >= DEPTH)
                r.overflow = 1'b1;
            else if (cmd == CMD_PUSH_FRONT)
            begin
                front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
                ring_words[front_slot] = word;
                word_count++;
            end
            else
            begin
                rear_slot = (rear_slot == DEPTH - 1) ? 0 : rear_slot + 1;
                ring_words[rear_slot] = word;
                word_count++;
            end
        end
        else
        begin
            if (word_count == 0)
                r.underflow = 1'b1;
            else if (word_count == 1)
            begin
                // The last word leaves, and both ends go back to slot 0.
                front_slot = 0;
                rear_slot  = 0;
                word_count = 0;
            end
            else if (cmd == CMD_POP_FRONT)
            begin
                front_slot = (front_slot == DEPTH - 1) ? 0 : front_slot + 1;
                word_count--;
            end
            else
            begin
                rear_slot = (rear_slot == 0) ? DEPTH - 1 : rear_slot - 1;
                word_count--;
            end
        end
        if (word_count != 0)
        begin
            r.front_word = ring_words[front_slot];
            r.rear_word  = ring_words[rear_slot];
        end
        r.count    = word_count[COUNT_W-1:0];
        r.is_empty = (word_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("Mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    // Driver: predicts each accepted item and offers the next pending one.
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        command_item_t item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command  <= CMD_PUSH_FRONT;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.insert(expected_results.size(),
                                        apply_command(cmd_t'(command), value));
                cmd_seen[command]++;
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item = pending_items[0];
                    pending_items.delete(0);
                    in_valid <= 1'b1;
                    command  <= item.cmd;
                    value    <= item.word;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result taken against the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        deque_result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("Result %0d arrived with nothing expected", results_seen);
                    mismatches++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (overflow !== want.overflow)
                        report_mismatch("overflow", overflow, want.overflow);
                    if (underflow !== want.underflow)
                        report_mismatch("underflow", underflow, want.underflow);
                    if (front_value !== want.front_word)
                        report_mismatch("front_value", front_value, want.front_word);
                    if (rear_value !== want.rear_word)
                        report_mismatch("rear_value", rear_value, want.rear_word);
                    if (count !== want.count)
                        report_mismatch("count", count, want.count);
                    if (is_empty !== want.is_empty)
                        report_mismatch("is_empty", is_empty, want.is_empty);
                    if (want.overflow)
                        overflows_seen++;
                    if (want.underflow)
                        underflows_seen++;
                    if (want.count == DEPTH)
                        full_seen++;
                end
                results_seen++;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_item(cmd_t cmd, logic signed [DATA_W-1:0] word);
        command_item_t item;
        item.cmd  = cmd;
        item.word = word;
        pending_items.insert(pending_items.size(), item);
    endtask

    // Mostly random words, with the extremes and alternating patterns mixed in.
    function automatic logic signed [DATA_W-1:0] pick_word();
        logic [DATA_W-1:0] w;
        w = $urandom;
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(4))
                0: w = 32'h8000_0000;
                1: w = 32'h7FFF_FFFF;
                2: w = 32'hFFFF_FFFF;
                3: w = 32'h0000_0000;
                default: w = $urandom_range(1) ? 32'h5555_5555 : 32'hAAAA_AAAA;
            endcase
        end
        return w;
    endfunction

    // Bursts with a push bias of 85, 50 or 15 percent drive the ring between empty and full.
    task automatic add_random_items(int total);
        int push_pct;
        int burst;
        cmd_t cmd;
        while (total > 0)
        begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            burst = $urandom_range(20, 4);
            if (burst > total)
                burst = total;
            repeat (burst)
            begin
                if ($urandom_range(99) < push_pct)
                    cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                add_item(cmd, pick_word());
            end
            total -= burst;
        end
    endtask

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 15;
        recv_stall_pct = 81;

        // Directed corner cases: empty pops, push and pop at the last word,
        // wrap of both ends, a full ring refusing pushes, draining to empty.
        add_item(CMD_POP_FRONT,  32'sd0);
        add_item(CMD_POP_BACK,   -32'sd1);
        add_item(CMD_PUSH_BACK,  32'sh7FFF_FFFF);
        add_item(CMD_POP_BACK,   32'sd0);
        add_item(CMD_PUSH_FRONT, 32'sh8000_0000);
        add_item(CMD_PUSH_FRONT, -32'sd1);
        add_item(CMD_PUSH_BACK,  32'sd0);
        add_item(CMD_PUSH_FRONT, 32'sh5555_5555);
        add_item(CMD_PUSH_BACK,  32'shAAAA_AAAA);
        add_item(CMD_PUSH_BACK,  32'sh1234_5678);
        add_item(CMD_PUSH_FRONT, 32'shEDCB_A987);
        add_item(CMD_PUSH_BACK,  32'sh0F0F_F0F0);
        add_item(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        add_item(CMD_PUSH_BACK,  32'sh8000_0000);
        add_item(CMD_POP_FRONT,  32'sh7FFF_FFFF);
        add_item(CMD_POP_FRONT,  32'sd0);
        add_item(CMD_POP_BACK,   32'sd0);
        add_item(CMD_POP_FRONT,  32'sd0);
        add_item(CMD_POP_BACK,   32'sd0);
        add_item(CMD_POP_FRONT,  32'sd0);
        add_item(CMD_POP_BACK,   32'sd0);
        add_item(CMD_POP_FRONT,  32'sd0);
        add_item(CMD_POP_BACK,   32'sd0);

        add_random_items(RANDOM_ITEMS / 3);
        // The sender holds off here until every result is back.
        wait_until_drained();

        send_idle_pct  = 81;
        recv_stall_pct = 15;
        add_random_items(RANDOM_ITEMS / 3);
        wait_until_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items (push front %0d, push back %0d, pop front %0d, pop back %0d)",
                 items_sent, cmd_seen[CMD_PUSH_FRONT], cmd_seen[CMD_PUSH_BACK],
                 cmd_seen[CMD_POP_FRONT], cmd_seen[CMD_POP_BACK]);
        $display("Checked %0d results: %0d full, %0d overflows, %0d underflows",
                 results_seen, full_seen, overflows_seen, underflows_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[circular_deque] OK");
        else
            $display("[circular_deque] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
test/circular_deque_test.sv
